/* rtl/sida_pkg.sv */
// Shared constants and types for the signed integer to decimal ASCII converter.
`default_nettype none

package sida_pkg;

  // Width of one output character code and of one BCD digit.
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  // ASCII codes that the converter emits.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // Status of the BCD conversion unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } sida_conv_status_t;

endpackage : sida_pkg

`default_nettype wire

/* rtl/sida_in_if.sv */
// Input channel: one signed integer per transaction.
`default_nettype none

interface sida_in_if #(
  parameter int INPUT_WIDTH = 32
);

  logic                          valid;
  logic                          ready;
  logic signed [INPUT_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface : sida_in_if

`default_nettype wire

/* rtl/sida_out_if.sv */
// Output channel: one ASCII character per transaction, with an end-of-number flag.
`default_nettype none

interface sida_out_if
  import sida_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);

endinterface : sida_out_if

`default_nettype wire

/* rtl/sida_bcd_conv.sv */
// Iterative binary to BCD converter using one shift and add-3 step per cycle.
`default_nettype none

module sida_bcd_conv
  import sida_pkg::*;
#(
  parameter int INPUT_WIDTH = 32,
  parameter int NUM_DIGITS  = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [INPUT_WIDTH-1:0]          mag_i,
  output sida_conv_status_t                    status_o,
  output logic      [DIGIT_W*NUM_DIGITS-1:0]   bcd_o
);

  localparam int BCD_W = DIGIT_W * NUM_DIGITS;
  localparam int CNT_W = $clog2(INPUT_WIDTH + 1);

  logic [INPUT_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  // Every digit of five or more gets three added before the shift, so that
  // it carries correctly into the next decade.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
        bcd_adj[DIGIT_W*i +: DIGIT_W] = bcd_q[DIGIT_W*i +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[DIGIT_W*i +: DIGIT_W] = bcd_q[DIGIT_W*i +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = CNT_W'(INPUT_WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[INPUT_WIDTH-1]};
      bin_d = {bin_q[INPUT_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign bcd_o         = bcd_q;

endmodule : sida_bcd_conv

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level: signed two's complement integer to decimal ASCII character stream.
// Each number passes through acceptance, a shift and add-3 step for every input bit, handoff
// of the digits, suppression of leading zeros, an optional minus sign, then its characters.
// A new number is taken only once the sequencer is back in idle after its last character.
// Reset is asynchronous and active low; it clears the sequencer and the output valid.
`default_nettype none

module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int INPUT_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sida_in_if.sink    in_i,
  sida_out_if.source out_o
);

  // Decimal digits needed for the largest magnitude, 2^(INPUT_WIDTH-1):
  // floor((INPUT_WIDTH-1) * log10(2)) + 1.
  localparam int NUM_DIGITS = ((INPUT_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int DCNT_W     = $clog2(NUM_DIGITS + 1);

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [BCD_W-1:0]        digits_q, digits_d;
  logic [DCNT_W-1:0]       dig_left_q, dig_left_d;
  logic                    neg_q, neg_d;
  logic                    out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]       char_q, char_d;
  logic                    last_q, last_d;

  logic                    in_xact;
  logic                    out_free;
  logic [INPUT_WIDTH-1:0]  in_bits;
  logic [INPUT_WIDTH-1:0]  magnitude;
  logic [DIGIT_W-1:0]      top_digit;
  sida_conv_status_t       conv_status;
  logic [BCD_W-1:0]        conv_bcd;

  // A new number is taken only when the sequencer is idle. The output register
  // may still hold the final character of the previous number at that point.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xact    = in_i.valid && (state_q == ST_IDLE);

  // The magnitude is the two's complement negation for negative inputs. For the
  // most negative value this yields only the top bit set, which read as an
  // unsigned number is exactly the right magnitude.
  assign in_bits   = in_i.value;
  assign magnitude = in_bits[INPUT_WIDTH-1] ? (~in_bits + INPUT_WIDTH'(1)) : in_bits;

  sida_bcd_conv #(
    .INPUT_WIDTH (INPUT_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_bcd_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xact),
    .mag_i    (magnitude),
    .status_o (conv_status),
    .bcd_o    (conv_bcd)
  );

  // The output register can be loaded when it is empty or is being drained
  // by an output transaction in this cycle.
  assign out_free  = !out_valid_q || out_o.ready;
  assign top_digit = digits_q[BCD_W-1 -: DIGIT_W];

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    dig_left_d  = dig_left_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    char_d      = char_q;
    last_d      = last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xact) begin
          neg_d   = in_bits[INPUT_WIDTH-1];
          state_d = ST_CONV;
        end
      end

      ST_CONV: begin
        if (conv_status.done) begin
          digits_d   = conv_bcd;
          dig_left_d = DCNT_W'(NUM_DIGITS);
          state_d    = ST_SKIP;
        end
      end

      // Drop leading zero digits, but always keep the units digit so that
      // zero still prints as a single '0'.
      ST_SKIP: begin
        if ((top_digit == '0) && (dig_left_q > DCNT_W'(1))) begin
          digits_d   = {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dig_left_d = dig_left_q - DCNT_W'(1);
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_EMIT;
        end
      end

      // One digit per cycle while the output register is free, most significant
      // first; the units digit closes the number and frees the input side.
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
          last_d      = (dig_left_q == DCNT_W'(1));
          digits_d    = {digits_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dig_left_d  = dig_left_q - DCNT_W'(1);
          if (dig_left_q == DCNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dig_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dig_left_q  <= dig_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    neg_q    <= neg_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  // The conversion unit only runs while the sequencer waits for it.
  a_conv_busy_in_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_status.busy |-> (state_q == ST_CONV))
    else $error("conversion unit busy outside the conversion state");

  // Completion is reported only to a sequencer that is waiting for it.
  a_conv_done_in_conv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_status.done |-> (state_q == ST_CONV))
    else $error("conversion completed outside the conversion state");

  // While digits are being emitted, at least one digit remains.
  a_emit_has_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (dig_left_q != '0))
    else $error("digit emission with no digits left");

endmodule : signed_int_to_decimal_ascii

`default_nettype wire

/* sim/signed_int_to_decimal_ascii_tb.sv */
// Self-checking testbench for the signed integer to decimal ASCII converter.
`default_nettype none

module signed_int_to_decimal_ascii_tb
  import sida_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The block is exercised at its default width.
  localparam int VALUE_W = 32;

  // Upper bound on the whole run, far beyond the slowest correct schedule:
  // about 280 numbers, each with its conversion and an input gap, and
  // 11 characters that may each wait out a receiver stall.
  localparam int RUN_LIMIT_NS = 4_000_000;

  // Length of the one long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 400;

  // One character of expected decimal text.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sida_in_if #(.INPUT_WIDTH(VALUE_W)) in_ch ();
  sida_out_if                         out_ch ();

  signed_int_to_decimal_ascii #(
    .INPUT_WIDTH(VALUE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Integers still waiting to be offered to the block, in order.
  logic signed [VALUE_W-1:0] pending_values[$];
  // Characters that accepted integers must still produce, oldest first.
  text_char_t                expected_chars[$];

  int   total_values;
  int   values_accepted;
  int   results_seen;
  int   error_count;
  int   send_gap;
  int   recv_stall;
  logic hold_rx;

  // Free-running clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Appends the decimal text of one integer to the expected characters. The
  // magnitude is taken as an unsigned quantity, so the most negative value
  // negates to 2^31 without overflowing.
  function automatic void push_decimal_text(logic signed [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits[10];
    int                 nd;
    text_char_t         c;
    mag = value;
    if (value[VALUE_W-1]) begin
      mag = ~mag + 1'b1;
    end
    if (mag == '0) begin
      c.code = CHAR_ZERO;
      c.last = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    nd = 0;
    while (mag != '0) begin
      digits[nd] = 4'(mag % 10);
      mag        = mag / 10;
      nd++;
    end
    if (value[VALUE_W-1]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + CHAR_W'(digits[i]);
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Idle cycles before the next transaction on either side. Every third
  // stretch of 24 transactions runs back to back with no idling at all.
  function automatic int draw_idle(int count);
    if ((count / 24) % 3 == 2) begin
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Random integer, weighted toward interesting digit counts and boundaries.
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] mag;
    logic [63:0]        p;
    logic               neg;
    int                 k;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: mag = $urandom_range(0, 999);
      3: begin
        // Uniform over a random number of decimal digits.
        k = $urandom_range(1, 10);
        p = 64'd1;
        repeat (k) p = p * 10;
        mag = VALUE_W'({32'd0, $urandom} % p);
      end
      4: begin
        // Powers of ten and their neighbors, where a digit rolls over.
        k = $urandom_range(0, 9);
        p = 64'd1;
        repeat (k) p = p * 10;
        mag = VALUE_W'(p) + VALUE_W'($urandom_range(0, 2)) - 1'b1;
      end
      default: begin
        // Close to either end of the range.
        mag = neg ? (32'h8000_0000 - VALUE_W'($urandom_range(0, 20)))
                  : (32'h7FFF_FFFF - VALUE_W'($urandom_range(0, 20)));
        return neg ? -$signed(mag) : $signed(mag);
      end
    endcase
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // Driver: offers one integer per transaction from the pending queue. The
  // expected text is recorded at the edge where the block takes the value.
  always @(posedge clk_i or negedge rst_ni) begin : feed_values
    int gap;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        push_decimal_text(in_ch.value);
        values_accepted <= values_accepted + 1;
        gap = draw_idle(values_accepted);
        if (gap == 0 && pending_values.size() > 0) begin
          // Valid stays high; only the payload moves on.
          in_ch.value <= pending_values.pop_front();
        end else begin
          // Valid drops here, and that counts toward the gap.
          in_ch.valid <= 1'b0;
          send_gap    <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!in_ch.valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_values.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values.pop_front();
        end
      end
    end
  end

  // Monitor: takes one character per transaction and compares it with the
  // oldest expectation. Ready drops for a random stall, possibly of none, after
  // each character and for the whole of the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : take_chars
    text_char_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_stall   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_chars.size() == 0) begin
          $error("unexpected result: character %0d, last %0b",
                 out_ch.character, out_ch.last);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.character !== want.code) begin
            $error("character: expected %0d, got %0d", want.code, out_ch.character);
            error_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            error_count++;
          end
        end
        recv_stall = draw_idle(results_seen);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ch.ready <= (recv_stall == 0) && !hold_rx;
    end
  end

  // Long receiver hold-off. The sender keeps offering numbers meanwhile, so
  // the block stalls part-way through emitting a number and has to refuse further input.
  initial begin
    hold_rx = 1'b0;
    wait (values_accepted >= 30);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Stimulus, reset and the end of the run.
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    values_accepted = 0;
    results_seen    = 0;
    error_count     = 0;

    // Directed part: zero, single digits, digit rollovers, both ends of the
    // range including the most negative value, and alternating bit patterns.
    pending_values.push_back(32'sd0);
    pending_values.push_back(32'sd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'sd9);
    pending_values.push_back(32'sd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'sd99);
    pending_values.push_back(32'sd100);
    pending_values.push_back(-32'sd101);
    pending_values.push_back(32'sh7FFF_FFFF);
    pending_values.push_back(32'sh8000_0000);
    pending_values.push_back(32'sh8000_0001);
    pending_values.push_back(32'sd1_000_000_000);
    pending_values.push_back(-32'sd1_000_000_000);
    pending_values.push_back(32'sd999_999_999);
    pending_values.push_back(32'sd123_456_789);
    pending_values.push_back(-32'sd987_654_321);
    pending_values.push_back(32'sh5555_5555);
    pending_values.push_back(32'shAAAA_AAAA);
    pending_values.push_back(32'sd1_000_000);
    pending_values.push_back(32'sd0);
    pending_values.push_back(-32'sd9);

    repeat (260) pending_values.push_back(random_value());
    total_values = pending_values.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (values_accepted == total_values);
    wait (expected_chars.size() == 0);
    // Let any stray character surface before the verdict.
    repeat (80) @(posedge clk_i);

    if (error_count == 0) begin
      $display("signed_int_to_decimal_ascii_tb: done, clean");
    end else begin
      $display("signed_int_to_decimal_ascii_tb: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #RUN_LIMIT_NS;
    $display("signed_int_to_decimal_ascii_tb: done, errors");
    $finish;
  end

endmodule : signed_int_to_decimal_ascii_tb

`default_nettype wire

/* sim.f */
rtl/sida_pkg.sv
rtl/sida_in_if.sv
rtl/sida_out_if.sv
rtl/sida_bcd_conv.sv
rtl/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_tb.sv
